/* rtl/core/sird_pkg.sv */
// Shared types, constants and helpers for the signed integer to radix digits block.
// No dependencies; every other file in rtl/core imports this package.
package sird_pkg;

  localparam int VALUE_W        = 32;               // input word width
  localparam int CHAR_W         = 8;                // output character width
  localparam int RADIX_W        = 5;                // radix register width
  localparam int SYMS_W         = 64;               // one symbol bank register
  localparam int NUM_SYMS       = 16;               // symbols in the table
  localparam int SYM_IW         = $clog2(NUM_SYMS); // symbol index width
  localparam int MAX_RADIX_DFLT = 16;

  // Digit buffer: base 2 of a 32-bit magnitude is the longest case.
  localparam int NDIG = VALUE_W;
  localparam int NDW  = $clog2(NDIG + 1);           // digit count 1..NDIG
  localparam int IDXW = $clog2(NDIG);               // digit index
  localparam int BCW  = $clog2(VALUE_W);            // input bit counter

  // Front to back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_RADIX   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SYMS_LO = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SYMS_HI = 2'd2;

  // Reserved characters
  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] SYM_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] SYM_NUL   = 8'h00;

  typedef struct packed {
    logic                       base_ok;
    logic [RADIX_W-1:0]         radix;
    logic [NUM_SYMS*CHAR_W-1:0] syms;   // symbol 0 in the lowest byte
  } cfg_view_t;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  function automatic logic [CHAR_W-1:0] sym_at(input logic [NUM_SYMS*CHAR_W-1:0] tbl,
                                               input logic [SYM_IW-1:0] idx);
    return tbl[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

/* rtl/core/sird_cfg.sv */
// Configuration registers and the registered base validity check.
// Depends on sird_pkg.
module sird_cfg
  import sird_pkg::*;
#(
  parameter int MAX_RADIX = MAX_RADIX_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [SYMS_W-1:0] cfg_wdata,
  output cfg_view_t         cfg_view
);

  logic [RADIX_W-1:0]         radix_r;
  logic [SYMS_W-1:0]          syms_lo_r;
  logic [SYMS_W-1:0]          syms_hi_r;
  logic                       base_ok_r;
  logic                       base_ok_nxt;
  logic [NUM_SYMS*CHAR_W-1:0] tbl;

  assign tbl = {syms_hi_r, syms_lo_r};

  // Radix range, pairwise duplicate and reserved-character checks on symbols in use.
  always_comb begin
    logic                 bad;
    logic [CHAR_W-1:0]    si;
    bad = (radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(MAX_RADIX));
    for (int i = 0; i < NUM_SYMS; i++) begin
      si = sym_at(tbl, SYM_IW'(i));
      if (RADIX_W'(i) < radix_r) begin
        if (si == SYM_NUL || si == SYM_PLUS || si == SYM_MINUS || si == SYM_SPACE)
          bad = 1'b1;
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if (RADIX_W'(j) < radix_r && sym_at(tbl, SYM_IW'(j)) == si)
            bad = 1'b1;
        end
      end
    end
    base_ok_nxt = !bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r   <= '0;
      syms_lo_r <= '0;
      syms_hi_r <= '0;
      base_ok_r <= 1'b0;
    end else begin
      base_ok_r <= base_ok_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX:   radix_r   <= cfg_wdata[RADIX_W-1:0];
          REG_SYMS_LO: syms_lo_r <= cfg_wdata;
          REG_SYMS_HI: syms_hi_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign cfg_view.base_ok = base_ok_r;
  assign cfg_view.radix   = radix_r;
  assign cfg_view.syms    = tbl;

endmodule

/* rtl/core/sird_front.sv */
// Front end: takes input transfers, splits sign and magnitude, drops items
// when the base is invalid. Depends on sird_pkg.
module sird_front
  import sird_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic signed [VALUE_W-1:0] in_tdata,
  input  logic                      base_ok,
  output logic                      push_vld,
  input  logic                      push_rdy,
  output item_t                     push_data
);

  logic               slot_vld_r, slot_vld_nxt;
  logic [VALUE_W-1:0] slot_val_r;
  logic               slot_go;
  logic               in_xfer;

  // An item with an invalid base leaves the slot without a push.
  assign slot_go   = base_ok ? push_rdy : 1'b1;
  assign in_tready = !slot_vld_r || slot_go;
  assign in_xfer   = in_tvalid && in_tready;

  assign push_vld       = slot_vld_r && base_ok;
  assign push_data.neg  = slot_val_r[VALUE_W-1];
  assign push_data.mag  = slot_val_r[VALUE_W-1] ? (VALUE_W'(0) - slot_val_r) : slot_val_r;

  always_comb begin
    slot_vld_nxt = slot_vld_r;
    if (in_xfer)
      slot_vld_nxt = 1'b1;
    else if (slot_go)
      slot_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_xfer)
      slot_val_r <= in_tdata;
    if (!rst_n)
      slot_vld_r <= 1'b0;
    else
      slot_vld_r <= slot_vld_nxt;
  end

endmodule

/* rtl/core/sird_queue.sv */
// Short FIFO of classified items between the front and back ends.
// Depends on sird_pkg.
module sird_queue
  import sird_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_vld,
  output logic  push_rdy,
  input  item_t push_data,
  output logic  pop_vld,
  input  logic  pop,
  output item_t pop_data
);

  item_t            mem_r [Q_DEPTH];
  logic [Q_PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign push_rdy = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_vld  = (cnt_r != '0);
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop && pop_vld;
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [Q_PW-1:0] ptr_inc(input logic [Q_PW-1:0] p);
    return (p == Q_PW'(Q_DEPTH - 1)) ? '0 : p + Q_PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= push_data;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)
        cnt_r <= cnt_r + Q_CW'(1);
      else if (do_pop && !do_push)
        cnt_r <= cnt_r - Q_CW'(1);
    end
  end

endmodule

/* rtl/core/sird_back.sv */
// Back end: bit-serial radix conversion into a digit buffer, then character
// output through a registered stage. Depends on sird_pkg.
module sird_back
  import sird_pkg::*;
#(
  parameter int MAX_RADIX = MAX_RADIX_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_view_t         cfg_view,
  input  logic              q_vld,
  output logic              q_pop,
  input  item_t             q_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,
  output logic              out_tlast
);

  localparam int DW  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int RW1 = RADIX_W + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [BCW-1:0]     bitcnt_r, bitcnt_nxt;
  logic [DW-1:0]      digits_r [NDIG];
  logic [DW-1:0]      digits_nxt [NDIG];
  logic [NDW-1:0]     nd_r, nd_nxt;
  logic [IDXW-1:0]    idx_r, idx_nxt;
  logic               sign_pend_r, sign_pend_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  // Doubling step of the digit buffer: digit k becomes 2*d + carry_in,
  // wrapped at the radix. Carries resolve through one add as generate /
  // propagate (propagate only happens for odd radix, 2*d == radix-1).
  logic [RW1-1:0]     r_ext;
  logic [NDIG-1:0]    gen, prop;
  logic [NDIG:0]      csum;
  logic [NDIG-1:0]    cin, cout;
  logic [DW-1:0]      step_dig [NDIG];
  logic [NDW-1:0]     nd_step;
  logic [NDW-1:0]     nd_m1;
  logic               can_load;

  assign r_ext = RW1'(cfg_view.radix);

  always_comb begin
    logic [RW1-1:0] twice;
    for (int k = 0; k < NDIG; k++) begin
      twice   = RW1'(digits_r[k]) << 1;
      gen[k]  = (twice >= r_ext);
      prop[k] = ((twice + RW1'(1)) == r_ext);
    end
  end

  assign csum = {1'b0, gen | prop} + {1'b0, gen} + (NDIG+1)'(mag_r[VALUE_W-1]);
  assign cin  = csum[NDIG-1:0] ^ prop;
  assign cout = {csum[NDIG], cin[NDIG-1:1]};

  always_comb begin
    logic [RW1-1:0] t;
    for (int k = 0; k < NDIG; k++) begin
      t = (RW1'(digits_r[k]) << 1) + RW1'(cin[k]);
      if (cout[k])
        t = t - r_ext;
      step_dig[k] = DW'(t);
    end
  end

  assign nd_m1   = nd_r - NDW'(1);
  assign nd_step = nd_r + NDW'(cout[nd_m1[IDXW-1:0]]);

  assign can_load = !out_vld_r || out_tready;
  assign q_pop    = (state_r == ST_IDLE) && q_vld;

  always_comb begin
    logic [NDW-1:0] nd_last;
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bitcnt_nxt    = bitcnt_r;
    digits_nxt    = digits_r;
    nd_nxt        = nd_r;
    idx_nxt       = idx_r;
    sign_pend_nxt = sign_pend_r;
    out_vld_nxt   = out_vld_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    nd_last       = nd_step - NDW'(1);

    if (out_vld_r && out_tready)
      out_vld_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          mag_nxt    = q_data.mag;
          neg_nxt    = q_data.neg;
          bitcnt_nxt = '0;
          nd_nxt     = NDW'(1);
          for (int k = 0; k < NDIG; k++)
            digits_nxt[k] = '0;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        digits_nxt = step_dig;
        nd_nxt     = nd_step;
        mag_nxt    = mag_r << 1;
        bitcnt_nxt = bitcnt_r + BCW'(1);
        if (bitcnt_r == BCW'(VALUE_W - 1)) begin
          idx_nxt       = nd_last[IDXW-1:0];
          sign_pend_nxt = neg_r;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_vld_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = SYM_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = sym_at(cfg_view.syms, SYM_IW'(digits_r[idx_r]));
            out_last_nxt = (idx_r == '0);
            if (idx_r == '0)
              state_nxt = ST_IDLE;
            else
              idx_nxt = idx_r - IDXW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    digits_r    <= digits_nxt;
    nd_r        <= nd_nxt;
    idx_r       <= idx_nxt;
    bitcnt_r    <= bitcnt_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sign_pend_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sign_pend_r <= sign_pend_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/core/signed_integer_to_radix_digits.sv */
// Top level: signed 32-bit integer to text in a configurable radix.
// Depends on sird_pkg, sird_cfg, sird_front, sird_queue, sird_back.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+------------------------------------
//   cfg_*    | in        | cfg_we            | cfg_index, cfg_wdata (64 bits)
//   in_*     | in        | in_tvalid/tready  | in_tdata[31:0] value (signed)
//   out_*    | out       | out_tvalid/tready | out_tdata[7:0] character, out_tlast
//
// A number leaves the queue, then the conversion takes one input bit per
// cycle (each bit doubles the digit buffer in the current radix), then the
// characters go out one per cycle while out_tready does not stall them.
// The back end holds one number at a time; the front end and a
// two-entry queue take the following items meanwhile.
// Reset is synchronous, active low; configuration registers reset to zero,
// which is an invalid base, so items are dropped until a base is written.
// A stall on out_tready holds the output register; the back end waits,
// then the queue fills and in_tready drops.
module signed_integer_to_radix_digits
  import sird_pkg::*;
#(
  parameter int MAX_RADIX = MAX_RADIX_DFLT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [CFG_IW-1:0]         cfg_index,
  input  logic [SYMS_W-1:0]         cfg_wdata,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic signed [VALUE_W-1:0] in_tdata,   // [31:0] value
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [CHAR_W-1:0]         out_tdata,  // [7:0] character
  output logic                      out_tlast   // final character of the number
);

  cfg_view_t cfg_view;
  item_t     push_data, pop_data;
  logic      push_vld, push_rdy;
  logic      q_vld, q_pop;

  sird_cfg #(.MAX_RADIX(MAX_RADIX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_view  (cfg_view)
  );

  // Front: input slot, sign/magnitude split, drop on invalid base.
  sird_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .base_ok   (cfg_view.base_ok),
    .push_vld  (push_vld),
    .push_rdy  (push_rdy),
    .push_data (push_data)
  );

  sird_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_rdy  (push_rdy),
    .push_data (push_data),
    .pop_vld   (q_vld),
    .pop       (q_pop),
    .pop_data  (pop_data)
  );

  // Back: conversion and character output.
  sird_back #(.MAX_RADIX(MAX_RADIX)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_view   (cfg_view),
    .q_vld      (q_vld),
    .q_pop      (q_pop),
    .q_data     (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/core/sird_check.sv */
// Port-level assertions for signed_integer_to_radix_digits, bound to the top.
// Depends on sird_pkg.
module sird_check
  import sird_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [CHAR_W-1:0] out_tdata,
  input logic              out_tlast
);

  // Output register is cleared by reset.
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A stalled transfer holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Symbols are screened, so reserved characters only appear as the sign.
  a_no_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != SYM_NUL && out_tdata != SYM_PLUS && out_tdata != SYM_SPACE)
    else $error("reserved character on output");

  // The sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == SYM_MINUS |-> !out_tlast)
    else $error("minus sign marked last");

endmodule

bind signed_integer_to_radix_digits sird_check u_check (.*);

/* bench/tb_signed_integer_to_radix_digits.sv */
`timescale 1ns / 1ps
// Testbench for signed_integer_to_radix_digits: a directed table, then random numbers
// under random symbol tables and idle patterns, every character checked in order.
// Depends on sird_pkg and the RTL under rtl/core; reads no files.
module tb_signed_integer_to_radix_digits;
  import sird_pkg::*;

  localparam int TXT_CHARS   = 33;                 // sign plus 32 binary digits
  localparam int TXT_W       = TXT_CHARS * CHAR_W;
  localparam int SETTLE      = 400;                // idle margin before a register write
  localparam int RAND_TARGET = 420;                // random numbers that must be spelled
  localparam int HOLD_CYCLES = 500;                // long output hold for the backpressure phase

  // One expected character of the result stream.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // One row of the directed table: either a register write or a number.
  // For a number, typed=1 means the expected text is given right-aligned in text
  // (first character in the highest used byte); all zeros means nothing comes out.
  typedef struct packed {
    logic               is_write;
    logic [CFG_IW-1:0]  reg_idx;
    logic [SYMS_W-1:0]  wdata;
    logic [VALUE_W-1:0] value;
    logic               typed;
    logic [TXT_W-1:0]   text;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IW-1:0]         cfg_index;
  logic [SYMS_W-1:0]         cfg_wdata;
  logic                      in_tvalid;
  logic                      in_tready;
  logic signed [VALUE_W-1:0] in_tdata;    // [31:0] value
  logic                      out_tvalid;
  logic                      out_tready;
  logic [CHAR_W-1:0]         out_tdata;   // [7:0] character
  logic                      out_tlast;

  // Bench copy of the configuration, updated as each write goes out.
  logic [RADIX_W-1:0]         cur_radix;
  logic [NUM_SYMS*CHAR_W-1:0] cur_syms;

  text_char_t expected_text[$];   // characters still owed by the block, oldest first
  dir_row_t   dir_rows[$];

  int errors          = 0;
  int chars_checked   = 0;
  int nums_spelled    = 0;
  int nums_dropped    = 0;
  int reg_writes      = 0;
  int bases_tried     = 0;
  int in_stall_cycles = 0;
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_req        = 0;
  int hold_left       = 0;
  int rand_start;
  bit sent_since_write = 1'b0;
  bit bad_base;

  signed_integer_to_radix_digits uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #(40_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_W-1:0] symbol_of(input int idx);
    return cur_syms[idx*CHAR_W +: CHAR_W];
  endfunction

  // Base is usable: radix 2..MAX_RADIX, the symbols in use distinct and none of
  // them NUL, plus, minus or space. Symbols past the radix do not matter.
  function automatic bit base_usable();
    logic [CHAR_W-1:0] s;
    if (cur_radix < 2 || cur_radix > MAX_RADIX_DFLT) return 1'b0;
    for (int i = 0; i < cur_radix; i++) begin
      s = symbol_of(i);
      if (s == SYM_NUL || s == SYM_PLUS || s == SYM_MINUS || s == SYM_SPACE) return 1'b0;
      for (int j = i + 1; j < cur_radix; j++)
        if (symbol_of(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Spell one number into expected_text: sign, then digits MSD first.
  // The magnitude of the most negative value is 2^31, which fits unsigned.
  function automatic void spell_value(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    int digit [VALUE_W];
    int n;
    mag = raw[VALUE_W-1] ? -raw : raw;
    n = 0;
    do begin
      digit[n] = int'(mag % cur_radix);
      mag = mag / cur_radix;
      n++;
    end while (mag != 0 && n < VALUE_W);
    if (raw[VALUE_W-1]) expected_text.push_back(text_char_t'{SYM_MINUS, 1'b0});
    for (int k = n - 1; k >= 0; k--)
      expected_text.push_back(text_char_t'{symbol_of(digit[k]), k == 0});
  endfunction

  // Queue a typed-in expectation; its length is the run of non-zero low bytes.
  function automatic void queue_text(input logic [TXT_W-1:0] text);
    int n;
    n = 0;
    while (n < TXT_CHARS && text[n*CHAR_W +: CHAR_W] != SYM_NUL) n++;
    for (int k = n - 1; k >= 0; k--)
      expected_text.push_back(text_char_t'{text[k*CHAR_W +: CHAR_W], k == 0});
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    errors++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // Every output transfer is matched against the oldest owed character.
  always @(posedge clk) begin : watch_out
    text_char_t want;
    if (rst_n && in_tvalid && !in_tready) in_stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        flag_error($sformatf("unexpected char 0x%02h last=%0b", out_tdata, out_tlast));
      end else begin
        want = expected_text.pop_front();
        if (out_tdata !== want.ch)
          flag_error($sformatf("char %0d: got 0x%02h, want 0x%02h",
                               chars_checked, out_tdata, want.ch));
        if (out_tlast !== want.last)
          flag_error($sformatf("char %0d (0x%02h): last got %b, want %b",
                               chars_checked, want.ch, out_tlast, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // Receiver: random stalls at stall_pct, or a long hold when one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Register write; the mirror is updated alongside, the block is idle here.
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [SYMS_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIX:   cur_radix = data[RADIX_W-1:0];
      REG_SYMS_LO: cur_syms[SYMS_W-1:0] = data;
      REG_SYMS_HI: cur_syms[2*SYMS_W-1:SYMS_W] = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // Offer one number; valid stays high across back-to-back numbers and only
  // drops for a random gap. Prediction is made at the transfer edge.
  task automatic send_value(input logic [VALUE_W-1:0] v, input bit typed,
                            input logic [TXT_W-1:0] text);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (base_usable()) nums_spelled++;
    else nums_dropped++;
    if (typed) queue_text(text);
    else if (base_usable()) spell_value(v);
    sent_since_write = 1'b1;
    @(negedge clk);
  endtask

  // Bring the block to idle: all owed characters seen, then enough cycles for
  // numbers dropped under a bad base to leave the pipeline.
  task automatic settle();
    in_tvalid <= 1'b0;
    if (sent_since_write) begin
      while (expected_text.size() != 0) @(posedge clk);
      repeat (SETTLE) @(negedge clk);
      sent_since_write = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void add_write(input logic [CFG_IW-1:0] idx,
                                    input logic [SYMS_W-1:0] data);
    dir_rows.push_back(dir_row_t'{1'b1, idx, data, '0, 1'b0, '0});
  endfunction

  function automatic void add_number(input logic [VALUE_W-1:0] v, input bit typed,
                                     input logic [TXT_W-1:0] text);
    dir_rows.push_back(dir_row_t'{1'b0, REG_RADIX, '0, v, typed, text});
  endfunction

  // Mix of full-range words, small magnitudes, scaled values and the extremes.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) v = -v;
      end
      3, 4: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Random symbol table and radix. A good base has distinct legal symbols in
  // use and junk beyond; a bad one breaks exactly one rule.
  task automatic pick_base(input bit bad);
    logic [NUM_SYMS*CHAR_W-1:0] tbl;
    logic [CHAR_W-1:0]          b;
    logic [SYMS_W-1:0]          rword;
    int r, a, z;
    bit clash;
    r   = $urandom_range(2, MAX_RADIX_DFLT);
    tbl = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < r; i++) begin
      do begin
        b     = CHAR_W'($urandom_range(1, 255));
        clash = (b == SYM_PLUS || b == SYM_MINUS || b == SYM_SPACE);
        for (int j = 0; j < i; j++)
          if (tbl[j*CHAR_W +: CHAR_W] == b) clash = 1'b1;
      end while (clash);
      tbl[i*CHAR_W +: CHAR_W] = b;
    end
    if (bad) begin
      a = $urandom_range(0, r - 1);
      case ($urandom_range(0, 2))
        0: r = $urandom_range(0, 1) ? $urandom_range(17, 31) : $urandom_range(0, 1);
        1: begin
          z = (a + $urandom_range(1, r - 1)) % r;
          tbl[a*CHAR_W +: CHAR_W] = tbl[z*CHAR_W +: CHAR_W];
        end
        default: begin
          case ($urandom_range(0, 3))
            0: b = SYM_NUL;
            1: b = SYM_PLUS;
            2: b = SYM_MINUS;
            default: b = SYM_SPACE;
          endcase
          tbl[a*CHAR_W +: CHAR_W] = b;
        end
      endcase
    end
    write_reg(REG_SYMS_LO, tbl[SYMS_W-1:0]);
    write_reg(REG_SYMS_HI, tbl[2*SYMS_W-1:SYMS_W]);
    // upper bits of the radix word are don't-care; keep them noisy
    rword = {$urandom, $urandom};
    rword[RADIX_W-1:0] = r[RADIX_W-1:0];
    write_reg(REG_RADIX, rword);
    bases_tried++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_RADIX;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cur_radix = '0;
    cur_syms  = '0;

    // After reset the radix is 0: numbers are swallowed.
    add_number(32'd5, 1'b1, '0);
    add_number(32'hFFFF_FFFF, 1'b1, '0);
    // Decimal with the usual digits, then the 32-bit extremes.
    add_write(REG_SYMS_LO, "76543210");
    add_write(REG_SYMS_HI, "FEDCBA98");
    add_write(REG_RADIX, 64'd10);
    add_number(32'd0, 1'b1, "0");
    add_number(32'h7FFF_FFFF, 1'b1, "2147483647");
    add_number(32'h8000_0000, 1'b1, "-2147483648");
    add_number(32'hFFFF_FFFF, 1'b1, "-1");
    add_number(32'd12345, 1'b0, '0);
    // Hex: full table in use, trailing zero digits on the most negative value.
    add_write(REG_RADIX, 64'd16);
    add_number(32'h7FFF_FFFF, 1'b1, "7FFFFFFF");
    add_number(32'h8000_0000, 1'b1, "-80000000");
    add_number(32'd255, 1'b1, "FF");
    add_number(32'hFFFF_FF00, 1'b1, "-100");
    // Binary: the longest text, sign plus 32 digits.
    add_write(REG_RADIX, 64'd2);
    add_number(32'h8000_0000, 1'b1,
               {"-1", "0000000000", "0000000000", "0000000000", "0"});
    add_number(32'h7FFF_FFFF, 1'b1,
               {"1111111111", "1111111111", "1111111111", "1"});
    add_number(32'd1, 1'b1, "1");
    // Radix out of range: too small, one past the table, register maximum.
    add_write(REG_RADIX, 64'd1);
    add_number(32'd7, 1'b1, '0);
    add_write(REG_RADIX, 64'd17);
    add_number(32'd7, 1'b1, '0);
    add_write(REG_RADIX, 64'd31);
    add_number(32'd7, 1'b1, '0);
    // Plus as symbol 15: bad at radix 16, ignored at radix 15.
    add_write(REG_SYMS_HI, "+EDCBA98");
    add_write(REG_RADIX, 64'd16);
    add_number(32'd100, 1'b1, '0);
    add_write(REG_RADIX, 64'd15);
    add_number(32'd100, 1'b0, '0);
    // Decimal with a repeated symbol, then each reserved byte as symbol 0.
    add_write(REG_RADIX, 64'd10);
    add_write(REG_SYMS_LO, "76543211");
    add_number(32'd9, 1'b1, '0);
    add_write(REG_SYMS_LO, "7654321+");
    add_number(32'd9, 1'b1, '0);
    add_write(REG_SYMS_LO, "7654321-");
    add_number(32'd9, 1'b1, '0);
    add_write(REG_SYMS_LO, "7654321 ");
    add_number(32'd9, 1'b1, '0);
    add_write(REG_SYMS_LO, 64'h3736_3534_3332_3100);
    add_number(32'd9, 1'b1, '0);
    // Base 3 on "abc" with reserved bytes and duplicates past the radix.
    add_write(REG_SYMS_LO, 64'h2B2D_2000_0063_6261);
    add_write(REG_RADIX, 64'd3);
    add_number(32'hFFFF_FFFB, 1'b1, "-bc");
    add_number(32'd0, 1'b1, "a");

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_write) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
      end else begin
        send_value(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].text);
      end
    end

    // Random phases: modes rotate none / sender idle / receiver stall / both;
    // every third phase runs a broken base, phase 4 holds the output off long
    // enough for the queue to fill and in_tready to drop.
    rand_start = nums_spelled;
    for (int ph = 0; nums_spelled - rand_start < RAND_TARGET; ph++) begin
      settle();
      bad_base = (ph % 3 == 2);
      pick_base(bad_base);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      if (ph == 4) begin
        @(posedge clk);
        hold_req = HOLD_CYCLES;
        @(negedge clk);
      end
      repeat (bad_base ? 10 : 60) send_value(random_value(), 1'b0, '0);
    end

    settle();

    $display("%0d numbers spelled, %0d dropped under invalid bases, %0d characters checked",
             nums_spelled, nums_dropped, chars_checked);
    $display("%0d random bases, %0d register writes, input stalled %0d cycles, %0d errors",
             bases_tried, reg_writes, in_stall_cycles, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sird_pkg.sv
rtl/core/sird_cfg.sv
rtl/core/sird_front.sv
rtl/core/sird_queue.sv
rtl/core/sird_back.sv
rtl/core/signed_integer_to_radix_digits.sv
rtl/core/sird_check.sv
bench/tb_signed_integer_to_radix_digits.sv
